@@ rtl/sm4_pkg.sv @@
// SM4 package: S-box, FK, CK, round functions and shared types.
`timescale 1ns / 1ps
package sm4_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int RK_AW = $clog2(ROUND_COUNT);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 3'd5;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } t_state;

    // Controller to key RAM interface.
    typedef struct packed {
        logic             we;
        logic [RK_AW-1:0] waddr;
        logic [31:0]      wdata;
        logic [RK_AW-1:0] raddr;
    } t_rk_req;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] subst_word(input logic [31:0] x);
        subst_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // CK word: byte j equals (4*i+j)*7 mod 256.
    function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
        logic [7:0] b0;
        b0 = 8'({i, 2'b00}) * 8'd7;
        ck_word = {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
    endfunction

    function automatic logic [31:0] key_t(input logic [31:0] x);
        logic [31:0] b;
        b = subst_word(x);
        key_t = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    function automatic logic [31:0] enc_t(input logic [31:0] x);
        logic [31:0] b;
        b = subst_word(x);
        enc_t = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

endpackage

@@ rtl/sm4_block_cipher_ecb_cbc.sv @@
// SM4 block cipher engine top level, ECB and CBC modes.
`timescale 1ns / 1ps
// Usage:
//  - Configuration channel (i_cfg_valid/o_cfg_ready, index, 64-bit data) takes
//    key halves, IV halves, chain mode and direction; write only while idle.
//    Writing either key half forces a fresh key expansion on the next block.
//  - Slave stream carries one 128-bit block per transaction, tuser bit 0 marks
//    the first block of a CBC message (chaining value reloads from the IV).
//  - Master stream returns one 128-bit block per transaction.
// Sequence: from acceptance to tvalid a block passes a load step, 32 rounds at
// one round per cycle through the round key memory read, and an output step.
// When keys must be expanded, key expansion comes first, one key word per
// cycle written to the same memory. Blocks are processed one at a time: the
// slave side is ready only while idle.
// Reset clears configuration, chaining value and the key-ready flag; the round
// key memory is not cleared, it is always filled before use.
// A stalled receiver holds the result in the output register; the next block
// may be accepted and worked on, and it waits in the output state until
// the previous result is taken.
module sm4_block_cipher_ecb_cbc (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // block_high[63:0], block_low[127:64]
    input  logic         s_axis_tuser,   // chain_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // result_high[63:0], result_low[127:64]
);
    import sm4_pkg::*;

    t_rk_req     w_rk_req;
    logic [31:0] w_rk_rdata;
    logic [127:0] w_out;

    // Always accept configuration writes.
    assign o_cfg_ready = 1'b1;

    sm4_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_block  ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .i_in_start  (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_block (w_out),
        .i_out_ready (m_axis_tready),
        .o_rk_req    (w_rk_req),
        .i_rk_rdata  (w_rk_rdata)
    );

    sm4_rk_ram u_rk_ram (
        .i_clk   (i_clk),
        .i_req   (w_rk_req),
        .o_rdata (w_rk_rdata)
    );

    // Core works high word first; swap back to the stream packing.
    assign m_axis_tdata = {w_out[63:0], w_out[127:64]};
endmodule

@@ rtl/sm4_rk_ram.sv @@
// SM4 round key memory: one write port, one registered read port.
`timescale 1ns / 1ps
module sm4_rk_ram (
    input  logic                i_clk,
    input  sm4_pkg::t_rk_req    i_req,
    output logic [31:0]         o_rdata
);
    import sm4_pkg::*;

    logic [31:0] r_mem [ROUND_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

@@ rtl/sm4_core.sv @@
// SM4 sequencer: key expansion, 32-round datapath and CBC chaining.
`timescale 1ns / 1ps
module sm4_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [sm4_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    input  logic [127:0]                  i_in_block,
    input  logic                          i_in_start,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    output logic [127:0]                  o_out_block,
    input  logic                          i_out_ready,
    output sm4_pkg::t_rk_req              o_rk_req,
    input  logic [31:0]                   i_rk_rdata
);
    import sm4_pkg::*;

    t_state r_state, n_state;
    logic [RK_AW-1:0] r_cnt, n_cnt;
    logic [127:0] r_key, r_iv, r_cv, n_cv;
    logic r_mode, r_dir, r_kready, n_kready;
    logic [31:0] r_x [4];
    logic [31:0] n_x [4];
    logic [127:0] r_blk, n_blk;
    logic [127:0] r_res, n_res;
    logic [127:0] w_cv_use, w_fin;
    logic [31:0] w_t;
    logic [RK_AW-1:0] w_raddr_first, w_raddr_next;
    logic r_start, n_start, r_ovalid, n_ovalid;

    assign w_raddr_first = r_dir ? RK_AW'(ROUND_COUNT - 1) : '0;
    assign w_raddr_next  = r_dir ? ~(r_cnt + RK_AW'(1)) : r_cnt + RK_AW'(1);
    assign w_cv_use = r_start ? r_iv : r_cv;
    assign w_fin = {r_x[3], r_x[2], r_x[1], r_x[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0; r_iv <= '0; r_mode <= 1'b0; r_dir <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY_HIGH:   r_key[127:64] <= i_cfg_data;
                REG_KEY_LOW:    r_key[63:0] <= i_cfg_data;
                REG_IV_HIGH:    r_iv[127:64] <= i_cfg_data;
                REG_IV_LOW:     r_iv[63:0] <= i_cfg_data;
                REG_CHAIN_MODE: r_mode <= i_cfg_data[0];
                REG_DIRECTION:  r_dir <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_kready <= 1'b0; r_cv <= '0; r_ovalid <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_kready <= (i_cfg_valid && (i_cfg_index == REG_KEY_HIGH ||
                         i_cfg_index == REG_KEY_LOW)) ? 1'b0 : n_kready;
            r_cv <= n_cv; r_ovalid <= n_ovalid; r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_blk <= n_blk; r_res <= n_res; r_start <= n_start;
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_kready = r_kready; n_cv = r_cv;
        n_x = r_x; n_blk = r_blk; n_res = r_res; n_start = r_start;
        n_ovalid = r_ovalid;
        o_in_ready = 1'b0;
        o_rk_req = '0;
        w_t = '0;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_rk_req.raddr = w_raddr_first;
                if (i_in_valid) begin
                    n_blk = i_in_block; n_start = i_in_start; n_cnt = '0;
                    if (r_kready) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_x[0] = r_key[127:96] ^ FK0; n_x[1] = r_key[95:64] ^ FK1;
                        n_x[2] = r_key[63:32] ^ FK2;  n_x[3] = r_key[31:0] ^ FK3;
                        n_state = ST_KEXP;
                    end
                end
            end
            ST_KEXP: begin
                w_t = r_x[0] ^ key_t(r_x[1] ^ r_x[2] ^ r_x[3] ^ ck_word(r_cnt));
                n_x[0] = r_x[1]; n_x[1] = r_x[2]; n_x[2] = r_x[3]; n_x[3] = w_t;
                o_rk_req.we = 1'b1; o_rk_req.waddr = r_cnt; o_rk_req.wdata = w_t;
                o_rk_req.raddr = w_raddr_first;
                n_cnt = r_cnt + RK_AW'(1);
                if (r_cnt == RK_AW'(ROUND_COUNT - 1)) begin
                    n_kready = 1'b1; n_state = ST_LOAD; n_cnt = '0;
                end
            end
            ST_LOAD: begin
                // Read of the first round key is in flight; load the state words.
                o_rk_req.raddr = w_raddr_first;
                if (r_mode && !r_dir) begin
                    {n_x[0], n_x[1], n_x[2], n_x[3]} = r_blk ^ w_cv_use;
                end else begin
                    {n_x[0], n_x[1], n_x[2], n_x[3]} = r_blk;
                end
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                w_t = r_x[0] ^ enc_t(r_x[1] ^ r_x[2] ^ r_x[3] ^ i_rk_rdata);
                n_x[0] = r_x[1]; n_x[1] = r_x[2]; n_x[2] = r_x[3]; n_x[3] = w_t;
                o_rk_req.raddr = w_raddr_next;
                n_cnt = r_cnt + RK_AW'(1);
                if (r_cnt == RK_AW'(ROUND_COUNT - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_rk_req.raddr = w_raddr_first;
                if (!r_ovalid || i_out_ready) begin
                    if (r_mode && r_dir) begin
                        n_res = w_fin ^ w_cv_use; n_cv = r_blk;
                    end else begin
                        n_res = w_fin;
                        if (r_mode) n_cv = w_fin;
                    end
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_block = r_res;
endmodule
